/* rtl/cmh_pkg.sv */
// Shared types, constants and the arctangent table for the compass heading block.
package cmh_pkg;

  // Sample, offset, difference and heading widths
  localparam int FIELD_W   = 20;
  localparam int OFFSET_W  = 18;
  localparam int DIFF_W    = 21;
  localparam int HEADING_W = 16;

  // CORDIC datapath: difference scaled by 2^24, plus room for gain and negation
  localparam int SCALE_BITS = 24;
  localparam int VEC_W      = 48;
  localparam int ANGLE_W    = 32;
  localparam int TABLE_LEN  = 24;
  localparam int PROD_W     = ANGLE_W + HEADING_W;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_X = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_Y = 1'b1;

  // Register reset values
  localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST = -18'sd6228;
  localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST = 18'sd14035;

  // Angle constants: binary angle, 2^32 is a full turn
  localparam logic [ANGLE_W-1:0]   ANGLE_HALF   = 32'h8000_0000;
  localparam logic [HEADING_W-1:0] HEADING_FULL = 16'd36000;
  localparam logic [PROD_W-1:0]    ROUND_HALF   = 48'h0000_8000_0000;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // One vector in flight through the rotation pipeline
  typedef struct packed {
    logic                     zero;
    logic signed [VEC_W-1:0]  a;
    logic signed [VEC_W-1:0]  b;
    logic [ANGLE_W-1:0]       ang;
  } cmh_vec_t;

endpackage

/* rtl/cmh_cordic.sv */
// Vectoring CORDIC pipeline: one registered microrotation per stage.
module cmh_cordic
  import cmh_pkg::*;
#(
  parameter int NUM_STAGES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s_valid,
  output logic     s_ready,
  input  cmh_vec_t s_vec,
  output logic     m_valid,
  input  logic     m_ready,
  output cmh_vec_t m_vec
);

  cmh_vec_t             vec_r [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES:0]   rdy;

  assign rdy[NUM_STAGES] = m_ready;
  assign s_ready         = rdy[0];
  assign m_valid         = vld_r[NUM_STAGES-1];
  assign m_vec           = vec_r[NUM_STAGES-1];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    cmh_vec_t src;
    logic     src_vld;
    cmh_vec_t vec_nxt;
    logic signed [VEC_W-1:0] sa;
    logic signed [VEC_W-1:0] sb;

    if (k == 0) begin : g_first
      assign src     = s_vec;
      assign src_vld = s_valid;
    end else begin : g_next
      assign src     = vec_r[k-1];
      assign src_vld = vld_r[k-1];
    end

    // A stage takes new data when empty or when its successor moves
    assign rdy[k] = !vld_r[k] || rdy[k+1];

    // Rotate toward the abscissa; arithmetic shift floors
    always_comb begin
      sa = src.a >>> k;
      sb = src.b >>> k;
      vec_nxt      = src;
      if (!src.b[VEC_W-1]) begin
        vec_nxt.a   = src.a + sb;
        vec_nxt.b   = src.b - sa;
        vec_nxt.ang = src.ang + ATAN_TURNS[k];
      end else begin
        vec_nxt.a   = src.a - sb;
        vec_nxt.b   = src.b + sa;
        vec_nxt.ang = src.ang - ATAN_TURNS[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld) begin
        vec_r[k] <= vec_nxt;
      end
    end
  end

endmodule

/* rtl/compass_heading_from_magnetometer.sv */
// Compass heading top level: offset removal, CORDIC angle, degree scaling.
// Throughput: one sample per cycle; every stage is a register with its own valid bit,
// and a stage holds only while the one after it is full and stalled.
// Reset (synchronous, rst_n low): all valid bits clear, offsets return to -6228 and 14035.
// Offsets are written through the cfg port; the user must write them only while no sample
// is in flight, since the block itself does not enforce this.
module compass_heading_from_magnetometer
  import cmh_pkg::*;
#(
  parameter int ANGLE_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,   // field_x [19:0], field_y [39:20]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // heading [15:0]
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [OFFSET_W-1:0]   cfg_wdata
);

  localparam int NSTG = (ANGLE_STAGES > TABLE_LEN) ? TABLE_LEN : ANGLE_STAGES;

  logic signed [OFFSET_W-1:0] offset_x_r;
  logic signed [OFFSET_W-1:0] offset_y_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= OFFSET_X_RST;
      offset_y_r <= OFFSET_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OFFSET_X: offset_x_r <= cfg_wdata;
        REG_OFFSET_Y: offset_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: remove hard-iron offsets
  logic                     dif_vld_r;
  logic                     dif_rdy;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt;
  logic [FIELD_W-1:0]       fx, fy;

  assign fx     = in_tdata[FIELD_W-1:0];
  assign fy     = in_tdata[2*FIELD_W-1:FIELD_W];
  assign dx_nxt = {fx[FIELD_W-1], fx} - {{(DIFF_W-OFFSET_W){offset_x_r[OFFSET_W-1]}}, offset_x_r};
  assign dy_nxt = {fy[FIELD_W-1], fy} - {{(DIFF_W-OFFSET_W){offset_y_r[OFFSET_W-1]}}, offset_y_r};

  logic pre_vld_r;
  logic pre_rdy;

  assign dif_rdy   = !dif_vld_r || pre_rdy;
  assign in_tready = dif_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dif_vld_r <= 1'b0;
    end else if (dif_rdy) begin
      dif_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (dif_rdy && in_tvalid) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  // Stage 2: scale, fold the left half plane, flag the zero vector
  cmh_vec_t                pre_r, pre_nxt;
  logic                    cor_s_rdy;
  logic signed [VEC_W-1:0] a_raw, b_raw;

  assign a_raw = {{(VEC_W-DIFF_W-SCALE_BITS){dy_r[DIFF_W-1]}}, dy_r, {SCALE_BITS{1'b0}}};
  assign b_raw = {{(VEC_W-DIFF_W-SCALE_BITS){dx_r[DIFF_W-1]}}, dx_r, {SCALE_BITS{1'b0}}};

  always_comb begin
    pre_nxt.zero = (dx_r == '0) && (dy_r == '0);
    if (dy_r[DIFF_W-1]) begin
      pre_nxt.a   = -a_raw;
      pre_nxt.b   = -b_raw;
      pre_nxt.ang = ANGLE_HALF;
    end else begin
      pre_nxt.a   = a_raw;
      pre_nxt.b   = b_raw;
      pre_nxt.ang = '0;
    end
  end

  assign pre_rdy = !pre_vld_r || cor_s_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (pre_rdy) begin
      pre_vld_r <= dif_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_rdy && dif_vld_r) begin
      pre_r <= pre_nxt;
    end
  end

  // Rotation pipeline
  logic     cor_m_vld;
  logic     mul_rdy;
  cmh_vec_t cor_m_vec;

  cmh_cordic #(
    .NUM_STAGES (NSTG)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (pre_vld_r),
    .s_ready (cor_s_rdy),
    .s_vec   (pre_r),
    .m_valid (cor_m_vld),
    .m_ready (mul_rdy),
    .m_vec   (cor_m_vec)
  );

  // Stage 3: scale the binary angle to hundredths of a degree
  logic              mul_vld_r;
  logic              mul_zero_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              out_rdy;

  assign prod_nxt = PROD_W'(cor_m_vec.ang) * PROD_W'(HEADING_FULL);
  assign mul_rdy  = !mul_vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (mul_rdy) begin
      mul_vld_r <= cor_m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_rdy && cor_m_vld) begin
      prod_r     <= prod_nxt;
      mul_zero_r <= cor_m_vec.zero;
    end
  end

  // Stage 4: round half up, wrap a full circle to zero, force zero for a zero vector
  logic                 out_vld_r;
  logic [HEADING_W-1:0] heading_r, heading_nxt;
  logic [PROD_W-1:0]    rounded;
  logic [HEADING_W-1:0] hd;

  assign rounded = prod_r + ROUND_HALF;
  assign hd      = rounded[PROD_W-1:ANGLE_W];

  always_comb begin
    if (mul_zero_r || (hd >= HEADING_FULL)) begin
      heading_nxt = '0;
    end else begin
      heading_nxt = hd;
    end
  end

  assign out_rdy = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && mul_vld_r) begin
      heading_r <= heading_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = heading_r;

  // Heading always lies below a full circle
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata < HEADING_FULL))
    else $error("heading out of range");

  // A zero vector always yields heading zero
  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_vld_r && mul_zero_r && out_rdy) |=> (out_tdata == '0))
    else $error("zero vector gave nonzero heading");

  // With the output empty, nothing upstream may hold off the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

/* sim/compass_heading_from_magnetometer_tb.sv */
`timescale 1ns / 100ps
// Testbench for the compass heading block: directed and random streaming traffic checked against a predictor.
module compass_heading_from_magnetometer_tb;
  import cmh_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int RUN_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int PIPE_LATENCY  = RUN_STAGES + 4;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_ITEMS   = 155;
  localparam int NUM_PHASES    = 6;

  // Predict headings from accepted samples and check them in order
  class heading_scoreboard;
    logic signed [OFFSET_W-1:0] off_x;
    logic signed [OFFSET_W-1:0] off_y;
    logic [HEADING_W-1:0]       expected_headings[$];
    int unsigned                mismatches;

    function new();
      off_x      = OFFSET_X_RST;
      off_y      = OFFSET_Y_RST;
      mismatches = 0;
    endfunction

    function void set_offset(logic [CFG_ADDR_W-1:0] addr, logic [OFFSET_W-1:0] value);
      case (addr)
        REG_OFFSET_X: off_x = value;
        REG_OFFSET_Y: off_y = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_headings.size();
    endfunction

    // Vectoring CORDIC on the offset-corrected sample, then scale to 0.01 degree
    function logic [HEADING_W-1:0] predict_heading(logic [FIELD_W-1:0] fx,
                                                   logic [FIELD_W-1:0] fy);
      longint             dx, dy, absc, ord, s_absc, s_ord;
      logic [ANGLE_W-1:0] ang;
      logic [63:0]        prod;
      logic [63:0]        h;
      dx = longint'($signed(fx)) - longint'(off_x);
      dy = longint'($signed(fy)) - longint'(off_y);
      if (dx == 0 && dy == 0)
        return '0;
      absc = dy * (longint'(1) << SCALE_BITS);
      ord  = dx * (longint'(1) << SCALE_BITS);
      ang  = '0;
      // Fold the left half plane over, starting from half a turn
      if (absc < 0) begin
        absc = -absc;
        ord  = -ord;
        ang  = ANGLE_HALF;
      end
      for (int i = 0; i < RUN_STAGES; i++) begin
        s_absc = absc >>> i;
        s_ord  = ord >>> i;
        if (ord >= 0) begin
          absc = absc + s_ord;
          ord  = ord - s_absc;
          ang  = ang + ATAN_TURNS[i];
        end else begin
          absc = absc - s_ord;
          ord  = ord + s_absc;
          ang  = ang - ATAN_TURNS[i];
        end
      end
      // Round half up; a full circle wraps to zero
      prod = 64'(ang) * 64'd36000 + 64'h8000_0000;
      h    = prod >> 32;
      if (h >= 64'(HEADING_FULL))
        h = '0;
      return h[HEADING_W-1:0];
    endfunction

    function void note_sample(logic [FIELD_W-1:0] fx, logic [FIELD_W-1:0] fy);
      expected_headings.push_back(predict_heading(fx, fy));
    endfunction

    function void check_heading(logic [HEADING_W-1:0] actual);
      logic [HEADING_W-1:0] want;
      if (expected_headings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected heading: expected none, actual %0d", $time, actual);
        return;
      end
      want = expected_headings.pop_front();
      if (actual !== want) begin
        mismatches++;
        $display("%0t: heading mismatch: expected %0d, actual %0d", $time, want, actual);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [39:0]           in_tdata   = '0;   // field_x [19:0], field_y [39:20]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;         // heading [15:0]
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [OFFSET_W-1:0]   cfg_wdata  = '0;

  heading_scoreboard sb;
  int unsigned       send_idle_pct = 30;
  int unsigned       recv_idle_pct = 30;
  bit                hold_request  = 1'b0;

  compass_heading_from_magnetometer #(
    .ANGLE_STAGES(CORDIC_STAGES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(0, 99) >= pct)
      return 0;
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one sample after an idle gap; leaves tvalid high after the transaction
  task automatic send_sample(input logic [FIELD_W-1:0] fx, input logic [FIELD_W-1:0] fy,
                             input int unsigned gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {fy, fx};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(fx, fy);
    @(negedge clk);
  endtask

  // Send a sample given relative to the current offsets
  task automatic send_rel(input int dx, input int dy, input int unsigned gap);
    send_sample(FIELD_W'(dx + int'(sb.off_x)), FIELD_W'(dy + int'(sb.off_y)), gap);
  endtask

  task automatic write_offset(input logic [CFG_ADDR_W-1:0] addr, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= OFFSET_W'(value);
    sb.set_offset(addr, OFFSET_W'(value));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every expected heading, then let the pipeline empty
  task automatic drain_pipeline();
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned idle_left;
    int unsigned hold_left;
    idle_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        out_tready <= 1'b0;
        idle_left--;
      end else begin
        out_tready <= 1'b1;
        idle_left = pick_gap(recv_idle_pct);
      end
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_heading(out_tdata);
  end

  initial begin
    int ox_set[NUM_PHASES];
    int oy_set[NUM_PHASES];
    int send_pct[NUM_PHASES];
    int recv_pct[NUM_PHASES];
    int kind;
    sb = new();
    ox_set   = '{-6228, -131072, 131071, 0, 0, 0};
    oy_set   = '{14035, 131071, -131072, 0, 0, 0};
    send_pct = '{30, 0, 0, 60, 10, 30};
    recv_pct = '{30, 20, 0, 10, 60, 30};
    ox_set[4] = int'($urandom_range(0, 200000)) - 100000;
    oy_set[4] = int'($urandom_range(0, 200000)) - 100000;
    ox_set[5] = int'($urandom_range(0, 262143)) - 131072;
    oy_set[5] = int'($urandom_range(0, 262143)) - 131072;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero vector, axes, wrap at full circle, left half plane, field extremes
    send_rel(0, 0, 0);
    send_rel(1, 0, 0);
    send_rel(-1, 0, 1);
    send_rel(0, 1, 0);
    send_rel(0, -1, 0);
    send_rel(-1, 300000, 2);
    send_rel(1, -300000, 0);
    send_rel(-1, -1, 0);
    send_rel(1, -1, 0);
    send_rel(-300000, -300000, 0);
    send_rel(300000, 1, 0);
    send_sample(20'h80000, 20'h80000, 0);
    send_sample(20'h7FFFF, 20'h7FFFF, 0);
    send_sample(20'h00000, 20'h00000, 0);
    send_sample(20'h80000, 20'h7FFFF, 3);
    send_sample(20'h7FFFF, 20'h80000, 0);
    send_sample(FIELD_W'(300000), FIELD_W'(-300000), 0);
    send_sample(FIELD_W'(-300000), FIELD_W'(300000), 0);
    in_tvalid <= 1'b0;

    // Random phases, each under its own offsets and idling mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipeline();
      write_offset(REG_OFFSET_X, ox_set[p]);
      write_offset(REG_OFFSET_Y, oy_set[p]);
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      if (p == 1)
        hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 70)
          send_sample(FIELD_W'(int'($urandom_range(0, 600000)) - 300000),
                      FIELD_W'(int'($urandom_range(0, 600000)) - 300000),
                      pick_gap(send_idle_pct));
        else if (kind < 80)
          send_rel(int'($urandom_range(0, 6)) - 3, int'($urandom_range(0, 6)) - 3,
                   pick_gap(send_idle_pct));
        else if (kind < 90)
          send_sample(FIELD_W'($urandom), FIELD_W'($urandom), pick_gap(send_idle_pct));
        else
          send_rel(-int'($urandom_range(0, 50)), int'($urandom_range(100000, 300000)),
                   pick_gap(send_idle_pct));
      end
      in_tvalid <= 1'b0;
    end

    drain_pipeline();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
